// ===== hdl/dpw_pkg.sv =====
`timescale 1ns / 1ps
package dpw_pkg;

    localparam int PIX_BITS_DEF = 12;

    localparam int DEPTH_W    = 16;
    localparam int COLOUR_W   = 8;
    localparam int INV_W      = 24;
    localparam int CEN_W      = 16;
    localparam int DMM_W      = 24;
    localparam int ROT_W      = 16;
    localparam int TRN_W      = 16;
    localparam int ZQ_W       = 32;
    localparam int T_W        = 31;
    localparam int P_W        = 46;
    localparam int OUT_W      = 24;
    localparam int ACC_W      = 64;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int M_DATA_W   = 3 * OUT_W + 3 * COLOUR_W;

    // clamp limits for the lateral terms
    localparam logic [31:0] T_LIM = 32'h3FFF_FFFF;
    localparam logic [47:0] P_LIM = 48'h1FFF_FFFF_FFFF;

    localparam logic [CFG_DATA_W-1:0] POSE_ROW0_RST = 64'h0000_0000_0000_4000;
    localparam logic [CFG_DATA_W-1:0] POSE_ROW1_RST = 64'h0000_0000_4000_0000;
    localparam logic [CFG_DATA_W-1:0] POSE_ROW2_RST = 64'h0000_4000_0000_0000;
    localparam logic [INV_W-1:0]      INV_FX_RST    = 24'd28383;
    localparam logic [INV_W-1:0]      INV_FY_RST    = 24'd28431;
    localparam logic [CEN_W-1:0]      CEN_X_RST     = 16'd5296;
    localparam logic [CEN_W-1:0]      CEN_Y_RST     = 16'd3744;
    localparam logic [DMM_W-1:0]      DMM_RST       = 24'd13107;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_POSE_ROW0,
        CFG_POSE_ROW1,
        CFG_POSE_ROW2,
        CFG_INV_FOCAL_X,
        CFG_INV_FOCAL_Y,
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_DEPTH_TO_MM
    } t_cfg_reg;

    typedef struct packed {
        logic [COLOUR_W-1:0] blue;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] red;
    } t_rgb;

    // same layout as the pose register word
    typedef struct packed {
        logic signed [TRN_W-1:0] t;
        logic signed [ROT_W-1:0] r2;
        logic signed [ROT_W-1:0] r1;
        logic signed [ROT_W-1:0] r0;
    } t_pose_row;

    typedef struct packed {
        logic [INV_W-1:0] inv_fx;
        logic [INV_W-1:0] inv_fy;
        logic [CEN_W-1:0] cen_x;
        logic [CEN_W-1:0] cen_y;
        logic [DMM_W-1:0] dmm;
    } t_cam_cfg;

    typedef struct packed {
        logic                  valid;
        logic signed [P_W-1:0] x;
        logic signed [P_W-1:0] y;
        logic [ZQ_W-1:0]       z;
        t_rgb                  rgb;
    } t_cam_pt;

    typedef struct packed {
        logic                    valid;
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
        t_rgb                    rgb;
    } t_world_pt;

endpackage

// ===== hdl/dpw_backproject.sv =====
`timescale 1ns / 1ps
module dpw_backproject
    import dpw_pkg::*;
#(
    parameter int PIX_BITS = PIX_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [DEPTH_W-1:0]  i_depth,
    input  logic [PIX_BITS-1:0] i_row,
    input  logic [PIX_BITS-1:0] i_col,
    input  t_rgb                i_rgb,
    input  t_cam_cfg            i_cfg,
    output t_cam_pt             o_pt
);

    localparam int DX_W = ((PIX_BITS + 4 > CEN_W) ? PIX_BITS + 4 : CEN_W) + 1;
    localparam int TP_W = DX_W + INV_W + 1;
    localparam int ZP_W = DEPTH_W + DMM_W;
    localparam int XP_W = T_W + ZQ_W + 1;

    localparam logic signed [TP_W:0] RND12 = (TP_W + 1)'(2048);
    localparam logic signed [TP_W:0] T_HI  = (TP_W + 1)'(T_LIM);
    localparam logic signed [TP_W:0] T_LO  = -T_HI;
    localparam logic signed [XP_W:0] RND16 = (XP_W + 1)'(32768);
    localparam logic signed [XP_W:0] P_HI  = (XP_W + 1)'(P_LIM);
    localparam logic signed [XP_W:0] P_LO  = -P_HI;
    localparam logic [ZP_W-1:0]      RND8  = ZP_W'(128);

    function automatic logic signed [TP_W-1:0] lat_prod(
        input logic [PIX_BITS-1:0] pix,
        input logic [CEN_W-1:0]    cen,
        input logic [INV_W-1:0]    inv
    );
        logic signed [DX_W-1:0]  dx;
        logic signed [INV_W:0]   inv_s;
        dx    = $signed(DX_W'({pix, 4'b0000}) - DX_W'(cen));
        inv_s = $signed({1'b0, inv});
        return TP_W'(dx) * TP_W'(inv_s);
    endfunction

    function automatic logic signed [T_W-1:0] round_t(input logic signed [TP_W-1:0] p);
        logic signed [TP_W:0] w;
        w = (TP_W + 1)'(p) + RND12;
        w = w >>> 12;
        if (w > T_HI) begin
            w = T_HI;
        end else if (w < T_LO) begin
            w = T_LO;
        end
        return T_W'(w);
    endfunction

    function automatic logic signed [P_W-1:0] round_p(input logic signed [XP_W-1:0] p);
        logic signed [XP_W:0] w;
        w = (XP_W + 1)'(p) + RND16;
        w = w >>> 16;
        if (w > P_HI) begin
            w = P_HI;
        end else if (w < P_LO) begin
            w = P_LO;
        end
        return P_W'(w);
    endfunction

    logic                   r1_valid, r2_valid, r3_valid, r4_valid;
    logic [ZP_W-1:0]        r1_zp;
    logic signed [TP_W-1:0] r1_txp, r1_typ;
    t_rgb                   r1_rgb, r2_rgb, r3_rgb, r4_rgb;
    logic [ZQ_W-1:0]        r2_z, r3_z, r4_z;
    logic signed [T_W-1:0]  r2_tx, r2_ty;
    logic signed [XP_W-1:0] r3_xp, r3_yp;
    logic signed [P_W-1:0]  r4_x, r4_y;

    logic [ZP_W-1:0]        n1_zp;
    logic signed [TP_W-1:0] n1_txp, n1_typ;
    logic [ZQ_W-1:0]        n2_z;
    logic signed [T_W-1:0]  n2_tx, n2_ty;
    logic signed [XP_W-1:0] n3_xp, n3_yp;
    logic signed [P_W-1:0]  n4_x, n4_y;

    always_comb begin
        n1_zp  = ZP_W'(i_depth) * ZP_W'(i_cfg.dmm);
        n1_txp = lat_prod(i_col, i_cfg.cen_x, i_cfg.inv_fx);
        n1_typ = lat_prod(i_row, i_cfg.cen_y, i_cfg.inv_fy);
    end

    always_comb begin
        n2_z  = ZQ_W'((r1_zp + RND8) >> 8);
        n2_tx = round_t(r1_txp);
        n2_ty = round_t(r1_typ);
    end

    always_comb begin
        n3_xp = XP_W'(r2_tx) * XP_W'($signed({1'b0, r2_z}));
        n3_yp = XP_W'(r2_ty) * XP_W'($signed({1'b0, r2_z}));
    end

    always_comb begin
        n4_x = round_p(r3_xp);
        n4_y = round_p(r3_yp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_zp  <= n1_zp;
            r1_txp <= n1_txp;
            r1_typ <= n1_typ;
            r1_rgb <= i_rgb;
            r2_z   <= n2_z;
            r2_tx  <= n2_tx;
            r2_ty  <= n2_ty;
            r2_rgb <= r1_rgb;
            r3_xp  <= n3_xp;
            r3_yp  <= n3_yp;
            r3_z   <= r2_z;
            r3_rgb <= r2_rgb;
            r4_x   <= n4_x;
            r4_y   <= n4_y;
            r4_z   <= r3_z;
            r4_rgb <= r3_rgb;
        end
    end

    assign o_pt = '{valid: r4_valid, x: r4_x, y: r4_y, z: r4_z, rgb: r4_rgb};

endmodule

// ===== hdl/dpw_transform.sv =====
`timescale 1ns / 1ps
module dpw_transform
    import dpw_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  t_cam_pt         i_pt,
    input  t_pose_row [2:0] i_pose,
    output t_world_pt       o_pt
);

    localparam int PR_W = ROT_W + P_W;

    localparam logic signed [ACC_W:0] RND22  = (ACC_W + 1)'(2097152);
    localparam logic signed [ACC_W:0] OUT_HI = (ACC_W + 1)'(8388607);
    localparam logic signed [ACC_W:0] OUT_LO = -OUT_HI - (ACC_W + 1)'(1);

    function automatic logic signed [OUT_W-1:0] finish(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [TRN_W-1:0] trn
    );
        logic signed [ACC_W:0] w;
        w = (ACC_W + 1)'(acc) + RND22;
        w = (w >>> 22) + (ACC_W + 1)'(trn);
        if (w > OUT_HI) begin
            w = OUT_HI;
        end else if (w < OUT_LO) begin
            w = OUT_LO;
        end
        return OUT_W'(w);
    endfunction

    logic                    r5_valid, r6_valid, r7_valid;
    logic signed [PR_W-1:0]  r5_prod [3][3];
    logic signed [ACC_W-1:0] r6_acc [3];
    logic signed [OUT_W-1:0] r7_world [3];
    t_rgb                    r5_rgb, r6_rgb, r7_rgb;

    logic signed [PR_W-1:0]  n5_prod [3][3];
    logic signed [ACC_W-1:0] n6_acc [3];
    logic signed [OUT_W-1:0] n7_world [3];
    logic signed [ZQ_W:0]    w_z_s;

    assign w_z_s = $signed({1'b0, i_pt.z});

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n5_prod[i][0] = PR_W'($signed(i_pose[i].r0)) * PR_W'($signed(i_pt.x));
            n5_prod[i][1] = PR_W'($signed(i_pose[i].r1)) * PR_W'($signed(i_pt.y));
            n5_prod[i][2] = PR_W'($signed(i_pose[i].r2)) * PR_W'(w_z_s);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n6_acc[i] = ACC_W'(r5_prod[i][0]) + ACC_W'(r5_prod[i][1])
                      + ACC_W'(r5_prod[i][2]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n7_world[i] = finish(r6_acc[i], $signed(i_pose[i].t));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
        end else if (i_en) begin
            r5_valid <= i_pt.valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_prod  <= n5_prod;
            r5_rgb   <= i_pt.rgb;
            r6_acc   <= n6_acc;
            r6_rgb   <= r5_rgb;
            r7_world <= n7_world;
            r7_rgb   <= r6_rgb;
        end
    end

    assign o_pt = '{valid: r7_valid, x: r7_world[0], y: r7_world[1], z: r7_world[2],
                    rgb: r7_rgb};

endmodule

// ===== hdl/depth_pixel_to_world_point_top.sv =====
`timescale 1ns / 1ps
// Depth pixel to world point.
// Slave stream: one depth pixel per transfer (depth, row, column, colour).
// A pixel with zero depth is consumed and gives no output transfer.
// Master stream: one world point per non-zero pixel, x/y/z in signed mm
// saturated to 24 bits, colour passed through.
// Config port: i_cfg_we writes i_cfg_wdata to the register at i_cfg_addr
// (pose rows 0..2, 1/fx, 1/fy, cx, cy, depth scale); write only while idle.
// Pipeline: seven register stages from input transfer to output valid
// (scale/offset multiply, round, lateral multiply, round, rotation
// multiply, sum, round/translate/saturate).
// Throughput: one pixel per cycle while the output is not stalled.
// Reset: synchronous, active low; pipeline emptied, registers to defaults
// (identity pose, fx 591.1, fy 590.1, centre 331/234, 0.2 mm per unit).
// Stall: the whole pipeline holds while the output transfer waits, and
// s_axis_tready drops in the same cycle; nothing is lost or repeated.
module depth_pixel_to_world_point_top
    import dpw_pkg::*;
#(
    parameter int PIXEL_INDEX_BITS = PIX_BITS_DEF,
    localparam int S_FIELDS_W = DEPTH_W + 2 * PIXEL_INDEX_BITS + 3 * COLOUR_W,
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // depth, pixel_row, pixel_col, red_in, green_in, blue_in; zero fill
    input  logic [S_DATA_W-1:0]   s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // world_x, world_y, world_z, red_out, green_out, blue_out
    output logic [M_DATA_W-1:0]   m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int ROW_LSB    = DEPTH_W;
    localparam int COL_LSB    = ROW_LSB + PIXEL_INDEX_BITS;
    localparam int RED_LSB    = COL_LSB + PIXEL_INDEX_BITS;

    t_pose_row [2:0] r_pose;
    t_cam_cfg        r_cam;
    t_cam_pt         w_cam_pt;
    t_world_pt       w_world;
    t_rgb            w_rgb_in;
    logic [DEPTH_W-1:0] w_depth;
    logic            w_en;
    logic            w_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose[0]    <= POSE_ROW0_RST;
            r_pose[1]    <= POSE_ROW1_RST;
            r_pose[2]    <= POSE_ROW2_RST;
            r_cam.inv_fx <= INV_FX_RST;
            r_cam.inv_fy <= INV_FY_RST;
            r_cam.cen_x  <= CEN_X_RST;
            r_cam.cen_y  <= CEN_Y_RST;
            r_cam.dmm    <= DMM_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_POSE_ROW0:   r_pose[0]    <= i_cfg_wdata;
                CFG_POSE_ROW1:   r_pose[1]    <= i_cfg_wdata;
                CFG_POSE_ROW2:   r_pose[2]    <= i_cfg_wdata;
                CFG_INV_FOCAL_X: r_cam.inv_fx <= i_cfg_wdata[INV_W-1:0];
                CFG_INV_FOCAL_Y: r_cam.inv_fy <= i_cfg_wdata[INV_W-1:0];
                CFG_CENTER_X:    r_cam.cen_x  <= i_cfg_wdata[CEN_W-1:0];
                CFG_CENTER_Y:    r_cam.cen_y  <= i_cfg_wdata[CEN_W-1:0];
                CFG_DEPTH_TO_MM: r_cam.dmm    <= i_cfg_wdata[DMM_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advances whenever the output register is free or being drained
    assign w_en          = !w_world.valid || m_axis_tready;
    assign s_axis_tready = w_en;

    assign w_depth        = s_axis_tdata[DEPTH_W-1:0];
    assign w_in_valid     = s_axis_tvalid && (w_depth != '0);
    assign w_rgb_in.red   = s_axis_tdata[RED_LSB +: COLOUR_W];
    assign w_rgb_in.green = s_axis_tdata[RED_LSB + COLOUR_W +: COLOUR_W];
    assign w_rgb_in.blue  = s_axis_tdata[RED_LSB + 2 * COLOUR_W +: COLOUR_W];

    dpw_backproject #(
        .PIX_BITS (PIXEL_INDEX_BITS)
    ) u_backproject (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_in_valid),
        .i_depth (w_depth),
        .i_row   (s_axis_tdata[ROW_LSB +: PIXEL_INDEX_BITS]),
        .i_col   (s_axis_tdata[COL_LSB +: PIXEL_INDEX_BITS]),
        .i_rgb   (w_rgb_in),
        .i_cfg   (r_cam),
        .o_pt    (w_cam_pt)
    );

    dpw_transform u_transform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_pt    (w_cam_pt),
        .i_pose  (r_pose),
        .o_pt    (w_world)
    );

    assign m_axis_tvalid = w_world.valid;
    assign m_axis_tdata  = {w_world.rgb.blue, w_world.rgb.green, w_world.rgb.red,
                            w_world.z, w_world.y, w_world.x};

endmodule

// ===== hdl/dpw_checker.sv =====
`timescale 1ns / 1ps
module dpw_checker
    import dpw_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tready,
    input logic                i_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] i_m_tdata
);

    // stalled output holds its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("output transfer changed while stalled");

    // input side only takes a pixel when the pipeline can move
    a_ready_follows: assert property (@(posedge i_clk)
        i_s_tready == (!i_m_tvalid || i_m_tready))
        else $error("input ready does not track output stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output valid after reset");

endmodule

bind depth_pixel_to_world_point_top dpw_checker u_dpw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
